@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the indexed list block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: ante -> cons");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: ante => cons");

`endif

@@ rtl/ilid_pkg.sv @@
// Package for the indexed list block: sizes, operation and status codes,
// cell control types. No dependencies.
`timescale 1ns / 1ps

package ilid_pkg;

    // List geometry
    localparam int CAPACITY    = 64;
    localparam int ENTRY_WIDTH = 64;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);

    // Stream field widths
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 7;
    localparam int IN_TDATA_W  = ((OP_W + POS_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_W + STATUS_W + CNT_W + 7) / 8) * 8;
    localparam int CMP_W    = (COUNT_W > POS_W) ? COUNT_W : POS_W;

    // Read reduction tree
    localparam int GROUP_SIZE  = 8;
    localparam int GROUP_COUNT = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
    localparam logic [OP_W-1:0] OP_REPLACE = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // What each cell does in a cycle
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_WRITE,
        KIND_INSERT,
        KIND_DELETE
    } cell_kind_t;

    // Broadcast control for the cell row
    typedef struct packed {
        cell_kind_t             kind;
        logic [IDX_W-1:0]       pos;
        logic [ENTRY_WIDTH-1:0] word;
    } cell_ctrl_t;

endpackage

@@ rtl/indexed_list_insert_delete.sv @@
// Indexed list top level: stream ports, operation decode, count register,
// row of ilid_cell instances and registered read tree. Depends on ilid_pkg.
`timescale 1ns / 1ps
// Usage:
//   Input channel s_*: one transaction carries operation, position and entry.
//   Operations: append, insert at index, replace, delete, read at index.
//   Output channel m_*: one transaction per input with read data, status and
//   the count after the operation.
// Timing:
//   The entry row and the count update at the edge that accepts the input.
//   The read value passes a two-level OR tree (groups of eight cells, then
//   the group results). The group results are registered at the edge that
//   accepts the input; the second level is combinational and feeds the
//   output register. One item is in flight at a time; a new input is not
//   accepted until the previous result has been taken.
// Reset:
//   rst_n clears the count, the control state and the output valid. Cell
//   contents are not cleared; only entries below the count are ever read.
// Stall:
//   While m_tvalid is high and m_tready is low the result holds and
//   s_tready stays low.

`include "assert_macros.svh"

module indexed_list_insert_delete
    import ilid_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [2:0] operation, [9:3] position, [73:10] entry, rest zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [63:0] read_data, [65:64] status, [72:66] count, rest zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_GATHER = 1'b1;

    logic                   state_reg, state_next;
    logic [COUNT_W-1:0]     held_reg, held_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   rd_en_reg, rd_en_next;
    logic [CNT_W-1:0]       count_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]      m_data_reg;
    logic [STATUS_W-1:0]    m_status_reg;
    logic [CNT_W-1:0]       m_count_reg;
    logic [ENTRY_WIDTH-1:0] grp_reg  [GROUP_COUNT];
    logic [ENTRY_WIDTH-1:0] grp_next [GROUP_COUNT];
    logic [ENTRY_WIDTH-1:0] tree_or;

    logic                   accept;
    logic [OP_W-1:0]        in_op;
    logic [POS_W-1:0]       in_pos;
    logic [DATA_W-1:0]      in_entry;
    logic [CMP_W-1:0]       pos_ext, held_ext;
    logic                   full;
    cell_ctrl_t             ctrl;

    logic [ENTRY_WIDTH-1:0] cell_word [CAPACITY];
    logic [ENTRY_WIDTH-1:0] cell_rd   [CAPACITY];

    // Input fields
    assign in_op    = s_tdata[OP_W-1:0];
    assign in_pos   = s_tdata[OP_W+POS_W-1:OP_W];
    assign in_entry = s_tdata[OP_W+POS_W+DATA_W-1:OP_W+POS_W];
    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign pos_ext  = CMP_W'(in_pos);
    assign held_ext = CMP_W'(held_reg);
    assign full     = (held_reg == COUNT_W'(CAPACITY));

    // Operation decode: range and fullness checks, cell control
    always_comb
    begin
        ctrl.kind   = KIND_NONE;
        ctrl.pos    = IDX_W'(in_pos);
        ctrl.word   = in_entry[ENTRY_WIDTH-1:0];
        held_next   = held_reg;
        status_next = status_reg;
        rd_en_next  = rd_en_reg;
        if (accept)
        begin
            status_next = STAT_DONE;
            rd_en_next  = 1'b0;
            unique case (in_op)
                OP_APPEND:
                begin
                    if (full)
                        status_next = STAT_FULL;
                    else
                    begin
                        ctrl.kind = KIND_WRITE;
                        ctrl.pos  = IDX_W'(held_reg);
                        held_next = held_reg + 1'b1;
                    end
                end
                OP_INSERT:
                begin
                    if (pos_ext > held_ext)
                        status_next = STAT_RANGE;
                    else if (full)
                        status_next = STAT_FULL;
                    else
                    begin
                        ctrl.kind = KIND_INSERT;
                        held_next = held_reg + 1'b1;
                    end
                end
                OP_REPLACE:
                begin
                    if (pos_ext >= held_ext)
                        status_next = STAT_RANGE;
                    else
                        ctrl.kind = KIND_WRITE;
                end
                OP_DELETE:
                begin
                    if (pos_ext >= held_ext)
                        status_next = STAT_RANGE;
                    else
                    begin
                        ctrl.kind = KIND_DELETE;
                        held_next = held_reg - 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (pos_ext >= held_ext)
                        status_next = STAT_RANGE;
                    else
                        rd_en_next = 1'b1;
                end
                default:
                begin
                    status_next = STAT_DONE;
                end
            endcase
        end
    end

    // Row of cells, each wired to its neighbors
    for (genvar c = 0; c < CAPACITY; c++)
    begin : g_cell
        logic [ENTRY_WIDTH-1:0] left_w, right_w;
        if (c == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = cell_word[c-1];
        end
        if (c == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = cell_word[c+1];
        end
        ilid_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .cell_index (IDX_W'(c)),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[c]),
            .read_word  (cell_rd[c])
        );
    end

    // First tree level: OR of each group of cells
    always_comb
    begin
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if (g * GROUP_SIZE + k < CAPACITY)
                    grp_next[g] = grp_next[g] | cell_rd[g * GROUP_SIZE + k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int g = 0; g < GROUP_COUNT; g++)
                grp_reg[g] <= grp_next[g];
        end
    end

    // Second tree level
    always_comb
    begin
        tree_or = '0;
        for (int g = 0; g < GROUP_COUNT; g++)
            tree_or = tree_or | grp_reg[g];
    end

    // Sequencer and output valid
    always_comb
    begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_GATHER;
            end
            S_GATHER:
            begin
                state_next   = S_IDLE;
                m_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
            status_reg  <= STAT_DONE;
            rd_en_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
            status_reg  <= status_next;
            rd_en_reg   <= rd_en_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            count_reg <= CNT_W'(held_next);
        if (state_reg == S_GATHER)
        begin
            m_data_reg   <= rd_en_reg ? DATA_W'(tree_or) : '0;
            m_status_reg <= status_reg;
            m_count_reg  <= count_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({m_count_reg, m_status_reg, m_data_reg});

    // Checks
    `ASSERT_IMPLIES(a_held_bound, clk, rst_n, 1'b1, held_reg <= COUNT_W'(CAPACITY))
    `ASSERT_IMPLIES(a_one_in_flight, clk, rst_n, m_valid_reg, !s_tready)
    `ASSERT_NEXT(a_accept_gathers, clk, rst_n, accept, state_reg == S_GATHER)
    `ASSERT_IMPLIES(a_count_tracks, clk, rst_n, m_valid_reg, m_count_reg == CNT_W'(held_reg))
    `ASSERT_IMPLIES(a_full_status, clk, rst_n, m_valid_reg && (m_status_reg == STAT_FULL),
                    full)

endmodule

@@ rtl/ilid_cell.sv @@
// One storage cell of the list row: holds an entry, loads it from the
// broadcast word or a neighbor. Depends on ilid_pkg.
`timescale 1ns / 1ps

module ilid_cell
    import ilid_pkg::*;
(
    input  logic                   clk,
    input  cell_ctrl_t             ctrl,
    input  logic [IDX_W-1:0]       cell_index,
    input  logic [ENTRY_WIDTH-1:0] left_word,   // from cell_index - 1
    input  logic [ENTRY_WIDTH-1:0] right_word,  // from cell_index + 1
    output logic [ENTRY_WIDTH-1:0] word,
    output logic [ENTRY_WIDTH-1:0] read_word
);

    logic [ENTRY_WIDTH-1:0] word_reg;
    logic [ENTRY_WIDTH-1:0] word_next;
    logic                   hit;

    assign hit = (cell_index == ctrl.pos);

    // Next entry: direct load, shift up on insert, shift down on delete
    always_comb
    begin
        word_next = word_reg;
        case (ctrl.kind)
            KIND_WRITE:
            begin
                if (hit)
                    word_next = ctrl.word;
            end
            KIND_INSERT:
            begin
                if (hit)
                    word_next = ctrl.word;
                else if (cell_index > ctrl.pos)
                    word_next = left_word;
            end
            KIND_DELETE:
            begin
                if (cell_index >= ctrl.pos)
                    word_next = right_word;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word      = word_reg;
    assign read_word = hit ? word_reg : '0;

endmodule

@@ tb/indexed_list_insert_delete_tb.sv @@
// Testbench for indexed_list_insert_delete: directed edge cases, a full-list
// test and random edit traffic under several idle/stall mixes.
// Depends on ilid_pkg and the indexed_list_insert_delete RTL.
`timescale 1ns / 1ps

module indexed_list_insert_delete_tb;
    import ilid_pkg::*;

    // One result transaction, fields listed from the highest bit down
    typedef struct packed {
        logic [6:0]  count;
        logic [1:0]  status;
        logic [63:0] read_data;
    } list_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Shadow copy of the list, updated as edits are accepted
    logic [63:0]  shadow_cells [CAPACITY];
    int           shadow_len = 0;
    bit           list_growing = 1'b1;
    list_result_t expected_results [$];

    // Idle control and tallies
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int n_edits       = 0;
    int n_results     = 0;
    int n_full        = 0;
    int n_range       = 0;
    int n_fail        = 0;

    always #2 clk = ~clk;

    indexed_list_insert_delete dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Apply one edit to the shadow list and return the result it should give
    function automatic list_result_t predict_edit(logic [2:0] op, logic [6:0] pos,
                                                  logic [63:0] word);
        list_result_t res;
        int p;
        res = '0;
        p = int'(pos);
        res.status = STAT_DONE;
        case (op)
            OP_APPEND:
                if (shadow_len >= CAPACITY)
                    res.status = STAT_FULL;
                else
                begin
                    shadow_cells[shadow_len] = word;
                    shadow_len++;
                end
            OP_INSERT:
                if (p > shadow_len)
                    res.status = STAT_RANGE;
                else if (shadow_len >= CAPACITY)
                    res.status = STAT_FULL;
                else
                begin
                    for (int i = shadow_len; i > p; i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[p] = word;
                    shadow_len++;
                end
            OP_REPLACE:
                if (p >= shadow_len)
                    res.status = STAT_RANGE;
                else
                    shadow_cells[p] = word;
            OP_DELETE:
                if (p >= shadow_len)
                    res.status = STAT_RANGE;
                else
                begin
                    for (int i = p; i + 1 < shadow_len; i++)
                        shadow_cells[i] = shadow_cells[i+1];
                    shadow_len--;
                end
            OP_READ:
                if (p >= shadow_len)
                    res.status = STAT_RANGE;
                else
                    res.read_data = shadow_cells[p];
            default: ;  // unused codes leave the list alone
        endcase
        res.count = 7'(shadow_len);
        return res;
    endfunction

    // Drive one edit, with an optional idle gap first; hold until accepted
    task automatic send_edit(input logic [2:0] op, input logic [6:0] pos,
                             input logic [63:0] word);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({word, pos, op});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(predict_edit(op, pos, word));
        n_edits++;
    endtask

    // Receiver readiness, redrawn every cycle
    always @(negedge clk)
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

    // Compare every result transaction with the oldest expectation
    always @(posedge clk)
    begin : result_check
        list_result_t got;
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[72:0];
            n_results++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result read_data=%h status=%0d count=%0d",
                         $time, got.read_data, got.status, got.count);
                n_fail++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.read_data !== want.read_data)
                begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, want.read_data, got.read_data);
                    n_fail++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    n_fail++;
                end
                if (got.count !== want.count)
                begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, want.count, got.count);
                    n_fail++;
                end
                if (want.status == STAT_FULL)
                    n_full++;
                if (want.status == STAT_RANGE)
                    n_range++;
            end
        end
    end

    function automatic logic [63:0] random_word();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        else if (r < 16)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // One random edit; the list drifts between empty and full
    task automatic random_edit();
        int r;
        int valid_top;
        logic [2:0] op;
        logic [6:0] pos;
        if (shadow_len == CAPACITY)
            list_growing = 1'b0;
        else if (shadow_len == 0)
            list_growing = 1'b1;
        else if ($urandom_range(99) < 2)
            list_growing = !list_growing;

        r = $urandom_range(99);
        if (r < 3)
            op = 3'($urandom_range(7, 5));
        else if (list_growing)
            op = (r < 28) ? OP_APPEND : (r < 53) ? OP_INSERT :
                 (r < 65) ? OP_REPLACE : (r < 78) ? OP_DELETE : OP_READ;
        else
            op = (r < 13) ? OP_APPEND : (r < 25) ? OP_INSERT :
                 (r < 37) ? OP_REPLACE : (r < 80) ? OP_DELETE : OP_READ;

        // Mostly legal positions, some on the boundary, some anywhere
        valid_top = (op == OP_INSERT) ? shadow_len : ((shadow_len > 0) ? shadow_len - 1 : 0);
        r = $urandom_range(99);
        if (r < 80)
            pos = 7'($urandom_range(valid_top, 0));
        else if (r < 92)
            pos = 7'(shadow_len);
        else
            pos = 7'($urandom_range(127, 0));

        send_edit(op, pos, random_word());
    endtask

    // Empty-list errors, unused codes, edits at the ends and in the middle
    task automatic test_directed_edges();
        send_edit(OP_READ,    7'd0,   64'h0);
        send_edit(OP_DELETE,  7'd0,   64'h0);
        send_edit(OP_REPLACE, 7'd0,   '1);
        send_edit(OP_INSERT,  7'd1,   '1);
        send_edit(3'd5,       7'd127, '1);
        send_edit(3'd6,       7'd64,  64'h0123_4567_89AB_CDEF);
        send_edit(3'd7,       7'd0,   '1);
        send_edit(OP_INSERT,  7'd0,   '1);
        send_edit(OP_APPEND,  7'd127, '0);
        send_edit(OP_APPEND,  7'd5,   64'hA5A5_A5A5_A5A5_A5A5);
        send_edit(OP_INSERT,  7'd1,   64'h5A5A_5A5A_5A5A_5A5A);
        send_edit(OP_INSERT,  7'd4,   64'h8000_0000_0000_0001);
        for (int i = 0; i <= 5; i++)
            send_edit(OP_READ, 7'(i), '1);
        send_edit(OP_READ,    7'd127, '0);
        send_edit(OP_REPLACE, 7'd2,   64'hFEDC_BA98_7654_3210);
        send_edit(OP_DELETE,  7'd0,   '1);
        send_edit(OP_DELETE,  7'd4,   '0);
        send_edit(OP_DELETE,  7'd3,   '0);
        send_edit(OP_INSERT,  7'd127, '1);
        send_edit(OP_READ,    7'd2,   '0);
    endtask

    // Fill to capacity, then hit full and boundary cases
    task automatic test_full_list();
        while (shadow_len < CAPACITY)
            send_edit(OP_APPEND, 7'($urandom_range(127, 0)), random_word());
        send_edit(OP_APPEND,  7'd0,             '1);
        send_edit(OP_INSERT,  7'd0,             '1);
        send_edit(OP_INSERT,  7'(CAPACITY),     '1);
        send_edit(OP_INSERT,  7'(CAPACITY + 1), '1);
        send_edit(OP_READ,    7'(CAPACITY - 1), '0);
        send_edit(OP_READ,    7'(CAPACITY),     '0);
        send_edit(OP_REPLACE, 7'(CAPACITY - 1), 64'h1234_5678_9ABC_DEF0);
        send_edit(OP_DELETE,  7'(CAPACITY),     '0);
        send_edit(OP_DELETE,  7'd0,             '0);
        send_edit(OP_INSERT,  7'd0,             64'hCAFE_0000_0000_BEEF);
        send_edit(OP_DELETE,  7'(CAPACITY - 1), '0);
        send_edit(OP_READ,    7'(CAPACITY - 2), '0);
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int n_items);
        send_idle_pct = sender_pct;
        stall_pct     = receiver_pct;
        repeat (n_items)
            random_edit();
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        int guard;
        guard = 0;
        @(negedge clk);
        s_tvalid <= 1'b0;
        stall_pct = 0;
        while (expected_results.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10)
            @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            n_fail++;
        end
    endtask

    initial
    begin
        repeat (12)
            @(negedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(negedge clk);

        test_directed_edges();
        test_full_list();
        test_random_traffic(0, 0, 115);
        test_random_traffic(64, 0, 115);
        test_random_traffic(0, 64, 115);
        test_random_traffic(26, 26, 115);
        drain_results();

        $display("Covered %0d list edits and %0d results: %0d full, %0d out of range.",
                 n_edits, n_results, n_full, n_range);
        $display("Traffic mixes: no idling, sender gaps, receiver stalls, both.");
        if (n_fail == 0)
            $display("[indexed_list_insert_delete] OK");
        else
            $display("[indexed_list_insert_delete] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("%0t: timeout", $time);
        $display("[indexed_list_insert_delete] ERROR");
        $finish;
    end

endmodule

@@ indexed_list_insert_delete.f @@
+incdir+rtl
rtl/ilid_pkg.sv
rtl/ilid_cell.sv
rtl/indexed_list_insert_delete.sv
tb/indexed_list_insert_delete_tb.sv
